>>> design/idr_pkg.sv
package idr_pkg;

    localparam int unsigned XLEN = 64;
    localparam int unsigned HLEN = 32;

    typedef logic [2:0] action_t;

    localparam action_t ACT_SDIV32 = 3'd0;
    localparam action_t ACT_UDIV32 = 3'd1;
    localparam action_t ACT_SREM32 = 3'd2;
    localparam action_t ACT_UREM32 = 3'd3;
    localparam action_t ACT_SDIV64 = 3'd4;
    localparam action_t ACT_UDIV64 = 3'd5;
    localparam action_t ACT_SREM64 = 3'd6;
    localparam action_t ACT_UREM64 = 3'd7;

    // Per-item control that travels down the pipe with the data.
    typedef struct packed {
        logic is_rem;
        logic wide;
        logic neg_res;
    } ctl_t;

endpackage

>>> design/idr_front.sv
module idr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  idr_pkg::action_t  action,
    input  logic [63:0]       dividend,
    input  logic [63:0]       divisor,
    output logic              vld_reg,
    output idr_pkg::ctl_t     ctl_reg,
    output logic [63:0]       num_reg,
    output logic [63:0]       den_reg
);
    import idr_pkg::*;

    logic        is_signed;
    logic        wide;
    logic [63:0] a_m;
    logic [63:0] b_m;
    logic        na;
    logic        nb;
    logic [63:0] mask;
    ctl_t        ctl_next;
    logic [63:0] num_next;
    logic [63:0] den_next;

    always_comb
    begin
        is_signed = ~action[0];
        wide      = action[2];
        mask      = wide ? {XLEN{1'b1}} : {{HLEN{1'b0}}, {HLEN{1'b1}}};
        a_m       = dividend & mask;
        b_m       = divisor & mask;
        na        = is_signed & (wide ? a_m[63] : a_m[31]);
        nb        = is_signed & (wide ? b_m[63] : b_m[31]);
        num_next  = na ? ((64'd0 - a_m) & mask) : a_m;
        den_next  = nb ? ((64'd0 - b_m) & mask) : b_m;
        ctl_next.is_rem  = action[1];
        ctl_next.wide    = wide;
        ctl_next.neg_res = action[1] ? na : (na ^ nb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg <= ctl_next;
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

endmodule

>>> design/idr_stage.sv
// STEPS restoring steps per stage: four quotient bits per stage when STEPS is 4.
module idr_stage
#(
    parameter int unsigned STEPS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              vld_in,
    input  idr_pkg::ctl_t     ctl_in,
    input  logic [63:0]       num_in,
    input  logic [63:0]       den_in,
    input  logic [63:0]       rem_in,
    output logic              vld_reg,
    output idr_pkg::ctl_t     ctl_reg,
    output logic [63:0]       num_reg,
    output logic [63:0]       den_reg,
    output logic [63:0]       rem_reg
);
    import idr_pkg::*;

    logic [63:0] num_w;
    logic [63:0] rem_w;
    logic [64:0] shf;
    logic [64:0] dif;

    // num shifts left; quotient bits enter at its bottom as dividend bits leave the top.
    always_comb
    begin
        num_w = num_in;
        rem_w = rem_in;
        for (int i = 0; i < STEPS; i++)
        begin
            shf = {rem_w, num_w[63]};
            dif = shf - {1'b0, den_in};
            if (!dif[64])
            begin
                rem_w = dif[63:0];
                num_w = {num_w[62:0], 1'b1};
            end
            else
            begin
                rem_w = shf[63:0];
                num_w = {num_w[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg <= ctl_in;
            num_reg <= num_w;
            den_reg <= den_in;
            rem_reg <= rem_w;
        end
    end

endmodule

>>> design/integer_div_rem_unit.sv
// Fully pipelined 64-bit integer divide/remainder unit (radix-2 restoring).
// An item is accepted in every cycle the pipe can advance; each result passes
// through one operand-conditioning stage, 16 divider stages of 4 restoring
// steps each (64 quotient bits), and one sign-fix/output stage. The whole
// pipe stalls together when the output is held, so nothing is lost or
// repeated. Division by zero yields quotient 0 and remainder equal to the
// dividend; the most negative value divided by minus one wraps. 32-bit
// operations zero-extend their results.
module integer_div_rem_unit
#(
    parameter int unsigned STEPS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  idr_pkg::action_t  action,
    input  logic [63:0]       dividend,
    input  logic [63:0]       divisor,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       result_value
);
    import idr_pkg::*;

    localparam int unsigned NSTG = XLEN / STEPS;

    logic        adv;
    logic        vld_a [NSTG+1];
    ctl_t        ctl_a [NSTG+1];
    logic [63:0] num_a [NSTG+1];
    logic [63:0] den_a [NSTG+1];
    logic [63:0] rem_a [NSTG+1];
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] res;
    logic [63:0] result_next;
    logic        out_valid_reg;
    logic [63:0] result_reg;

    // Advance the whole pipe whenever the output slot is free or being taken.
    assign adv      = ~out_valid_reg | out_ready;
    assign in_ready = adv;

    idr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_valid),
        .action   (action),
        .dividend (dividend),
        .divisor  (divisor),
        .vld_reg  (vld_a[0]),
        .ctl_reg  (ctl_a[0]),
        .num_reg  (num_a[0]),
        .den_reg  (den_a[0])
    );
    assign rem_a[0] = '0;

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stg
        idr_stage #(.STEPS(STEPS)) u_stg
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vld_in  (vld_a[g]),
            .ctl_in  (ctl_a[g]),
            .num_in  (num_a[g]),
            .den_in  (den_a[g]),
            .rem_in  (rem_a[g]),
            .vld_reg (vld_a[g+1]),
            .ctl_reg (ctl_a[g+1]),
            .num_reg (num_a[g+1]),
            .den_reg (den_a[g+1]),
            .rem_reg (rem_a[g+1])
        );
    end

    // Zero divisor: the steps give all-ones quotient and remainder = dividend;
    // force quotient to zero.
    always_comb
    begin
        q = (den_a[NSTG] == 64'd0) ? 64'd0 : num_a[NSTG];
        r = rem_a[NSTG];
        res = ctl_a[NSTG].is_rem ? r : q;
        if (ctl_a[NSTG].neg_res)
        begin
            res = 64'd0 - res;
        end
        result_next = ctl_a[NSTG].wide ? res : {{HLEN{1'b0}}, res[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_a[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;

endmodule

>>> tb/sv/idr_checker.sv
`timescale 1ns / 1ps

module idr_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  idr_pkg::action_t  action,
    input  logic [63:0]       dividend,
    input  logic [63:0]       divisor,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [63:0]       result_value,
    output int                fail_count,
    output int                pending,
    output int                result_count
);
    import idr_pkg::*;

    logic [63:0] expected_results[$];

    function automatic logic [63:0] div_rem_value(action_t op, logic [63:0] a_in,
                                                  logic [63:0] b_in);
        logic        sgn;
        logic        rem;
        logic        w;
        logic [63:0] mask;
        logic [63:0] sbit;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] res;
        logic        na;
        logic        nb;
        logic        carry;
        sgn  = !op[0];
        rem  = op[1];
        w    = op[2];
        mask = w ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        sbit = w ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        a    = a_in & mask;
        b    = b_in & mask;
        na   = 1'b0;
        nb   = 1'b0;
        if (sgn)
        begin
            na = (a & sbit) != 64'd0;
            nb = (b & sbit) != 64'd0;
            if (na) a = (64'd0 - a) & mask;
            if (nb) b = (64'd0 - b) & mask;
        end
        if (b == 64'd0)
        begin
            q = 64'd0;
            r = a;
        end
        else
        begin
            q = 64'd0;
            r = 64'd0;
            for (int i = 63; i >= 0; i--)
            begin
                carry = r[63];
                r = {r[62:0], a[i]};
                if (carry || r >= b)
                begin
                    r = r - b;
                    q[i] = 1'b1;
                end
            end
        end
        if (rem)
            res = (sgn && na) ? (64'd0 - r) : r;
        else
            res = (sgn && (na != nb)) ? (64'd0 - q) : q;
        return res & mask;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count   <= 0;
            result_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(div_rem_value(action, dividend, divisor));
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (result_value !== expected_results[0])
                    begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, expected_results[0], result_value);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import idr_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    action_t     action;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_value;
    int          fail_count;
    int          pending;
    int          result_count;
    int          item_count;
    bit          sending_done;
    bit          long_hold_done;

    integer_div_rem_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .dividend     (dividend),
        .divisor      (divisor),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value)
    );

    // Watch both channels, predict each result and compare in order.
    idr_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .dividend     (dividend),
        .divisor      (divisor),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Pick an operand with a bias toward the corner values of either width.
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = {v[63:32], 32'h8000_0000};
            4: v = {v[63:32], 32'hFFFF_FFFF};
            5: v = 64'd1;
            6: v = v >> $urandom_range(1, 63);
            7: v = {v[63:32], 32'h0} | {32'h0, (v[31:0] >> $urandom_range(1, 31))};
            default: ;
        endcase
        return v;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(action_t op, logic [63:0] a, logic [63:0] b);
        in_valid <= 1'b1;
        action   <= op;
        dividend <= a;
        divisor  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        item_count++;
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Receiver: random stall pattern, one long hold-off to fill the pipe.
    initial
    begin
        int hold;
        out_ready      = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && item_count > 300)
            begin
                // Hold off long enough that the pipe backs up into the input.
                out_ready <= 1'b0;
                repeat (120) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (sending_done)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                hold = $urandom_range(0, 3);
                out_ready <= ((item_count / 200) % 2 == 1) || (hold != 0) ||
                             ($urandom_range(0, 1) == 1);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int          burst;
        action_t     op;
        in_valid     = 1'b0;
        action       = ACT_SDIV32;
        dividend     = '0;
        divisor      = '0;
        item_count   = 0;
        sending_done = 1'b0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation on the corner cases of division.
        send_item(ACT_SDIV64, 64'h8000_0000_0000_0000, '1);
        send_item(ACT_SREM64, 64'h8000_0000_0000_0000, '1);
        send_item(ACT_SDIV32, 64'hDEAD_BEEF_8000_0000, 64'h1234_5678_FFFF_FFFF);
        send_item(ACT_SREM32, 64'h0000_0001_8000_0000, 64'h0000_0000_FFFF_FFFF);
        send_item(ACT_UDIV64, '1, 64'd0);
        send_item(ACT_UREM64, '1, 64'd0);
        send_item(ACT_SDIV64, 64'h8000_0000_0000_0005, 64'd0);
        send_item(ACT_SREM64, 64'h8000_0000_0000_0005, 64'd0);
        send_item(ACT_UDIV32, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
        send_item(ACT_UREM32, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0000);
        send_item(ACT_SDIV32, 64'h0000_0000_FFFF_FFF9, 64'd2);
        send_item(ACT_SREM32, 64'h0000_0000_FFFF_FFF9, 64'd2);
        send_item(ACT_SREM64, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(ACT_UDIV64, '1, 64'd1);
        send_item(ACT_UREM64, '1, 64'h8000_0000_0000_0000);
        send_item(ACT_UDIV32, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
        send_item(ACT_UREM32, 64'd0, 64'd7);
        send_item(ACT_SDIV64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        idle_gap(3);

        // Random: bursts of items with random gaps between them.
        while (item_count < RANDOM_ITEMS + 18)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                op = action_t'($urandom_range(0, 7));
                send_item(op, pick_operand(), pick_operand());
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 25));
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d items sent, %0d results checked", item_count, result_count);
        $display("tb: all 8 operations, zero divisors, overflow, random stalls");
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> integer_div_rem_unit.f
design/idr_pkg.sv
design/idr_front.sv
design/idr_stage.sv
design/integer_div_rem_unit.sv
tb/sv/idr_checker.sv
tb/sv/tb.sv
